### src/wal_record_sequencer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the log record sequencer
// Checks are clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef WAL_RECORD_SEQUENCER_ASSERT_SVH
`define WAL_RECORD_SEQUENCER_ASSERT_SVH

// Same-cycle implication
`define WRS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define WRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/wrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_pkg
// Shared types and constants of the log record sequencer.
// ----------------------------------------------------------------------------
package wrs_pkg;

	localparam int MAX_ACTIVE_DEF = 64;

	localparam logic [2:0] KIND_BEGIN  = 3'd0;
	localparam logic [2:0] KIND_UPDATE = 3'd1;
	localparam logic [2:0] KIND_ALLOC  = 3'd2;
	localparam logic [2:0] KIND_FREE   = 3'd3;
	localparam logic [2:0] KIND_COMMIT = 3'd4;
	localparam logic [2:0] KIND_ABORT  = 3'd5;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_FULL   = 2'd1;
	localparam logic [1:0] STAT_TFULL  = 2'd2;
	localparam logic [1:0] STAT_ZERO   = 2'd3;

	localparam logic [2:0] REG_BUFFER     = 3'd0;
	localparam logic [2:0] REG_HEADER     = 3'd1;
	localparam logic [2:0] REG_UPD_FIXED  = 3'd2;
	localparam logic [2:0] REG_PAGE_PL    = 3'd3;
	localparam logic [2:0] REG_FIRST_LSN  = 3'd4;
	localparam logic [2:0] REG_FIRST_TXID = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SIZE,
		ST_CHECK,
		ST_RD,
		ST_CMP,
		ST_UPD,
		ST_INS,
		ST_SH_RD,
		ST_SH_WR,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic size;
		logic check;
		logic rd_plus1;
		logic cmp_step;
		logic upd;
		logic ins;
		logic shift_wr;
		logic shift_done;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic kind_ok;
		logic fail;
		logic more;
		logic hit;
		logic more_shift;
		logic found;
		logic is_begin;
		logic is_remove;
		logic out_free;
	} sts_t;

endpackage

### src/wrs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wrs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### src/wrs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_ctrl
// Sequencer state machine: size, check, table scan, update, insert, shift and emit.
// ----------------------------------------------------------------------------
module wrs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  wrs_pkg::sts_t sts,
	output wrs_pkg::cmd_t cmd
);

	wrs_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wrs_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			wrs_pkg::ST_IDLE: begin
				if (in_valid && sts.kind_ok) state_nx = wrs_pkg::ST_SIZE;
			end
			wrs_pkg::ST_SIZE:  state_nx = wrs_pkg::ST_CHECK;
			wrs_pkg::ST_CHECK: state_nx = sts.fail ? wrs_pkg::ST_EMIT : wrs_pkg::ST_RD;
			wrs_pkg::ST_RD:    state_nx = sts.more ? wrs_pkg::ST_CMP : wrs_pkg::ST_UPD;
			wrs_pkg::ST_CMP:   state_nx = sts.hit ? wrs_pkg::ST_UPD : wrs_pkg::ST_RD;
			wrs_pkg::ST_UPD: begin
				if (sts.is_begin) state_nx = wrs_pkg::ST_INS;
				else if (sts.is_remove && sts.found) state_nx = wrs_pkg::ST_SH_RD;
				else state_nx = wrs_pkg::ST_EMIT;
			end
			wrs_pkg::ST_INS:   state_nx = wrs_pkg::ST_EMIT;
			wrs_pkg::ST_SH_RD: state_nx = sts.more_shift ? wrs_pkg::ST_SH_WR : wrs_pkg::ST_EMIT;
			wrs_pkg::ST_SH_WR: state_nx = wrs_pkg::ST_SH_RD;
			wrs_pkg::ST_EMIT: begin
				if (sts.out_free) state_nx = wrs_pkg::ST_IDLE;
			end
			default: state_nx = wrs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			wrs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			wrs_pkg::ST_SIZE:  cmd.size = 1'b1;
			wrs_pkg::ST_CHECK: cmd.check = 1'b1;
			wrs_pkg::ST_RD:    ;
			wrs_pkg::ST_CMP:   cmd.cmp_step = 1'b1;
			wrs_pkg::ST_UPD:   cmd.upd = 1'b1;
			wrs_pkg::ST_INS:   cmd.ins = 1'b1;
			wrs_pkg::ST_SH_RD: begin
				cmd.rd_plus1   = 1'b1;
				cmd.shift_done = !sts.more_shift;
			end
			wrs_pkg::ST_SH_WR: cmd.shift_wr = 1'b1;
			wrs_pkg::ST_EMIT:  cmd.emit = sts.out_free;
			default: ;
		endcase
	end

endmodule

### src/wrs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_dp
// Datapath: configuration, counters, record sizing, table and result register.
// ----------------------------------------------------------------------------
module wrs_dp #(
	parameter int MAX_ACTIVE = wrs_pkg::MAX_ACTIVE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wen,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data,
	input  logic [2:0]    in_kind,
	input  logic [95:0]   in_data,
	input  wrs_pkg::cmd_t cmd,
	output wrs_pkg::sts_t sts,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [4:0]    out_user,
	output logic [207:0]  out_data
);

	localparam int IW = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;
	localparam int CW = $clog2(MAX_ACTIVE + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ACTIVE);

	logic [23:0] buf_q;
	logic [7:0]  hdr_q, upd_fix_q, page_pl_q;
	logic [31:0] next_seq_q, next_txn_q;
	logic [23:0] fill_q;
	logic [CW-1:0] count_q, scan_q;
	logic [IW-1:0] hit_q;

	logic [2:0]  kind_q;
	logic [31:0] txn_q, page_q;
	logic [15:0] off_q, len_q;

	logic [15:0] data_q;
	logic [16:0] total_q;
	logic [31:0] tx_q, seq_q, prev_q;
	logic [23:0] pos_q;
	logic        fb_q, fail_q, found_q;
	logic [1:0]  status_q;

	logic        out_valid_q;
	logic [4:0]  out_user_q;
	logic [207:0] out_data_q;

	logic        ram_we;
	logic [IW-1:0] ram_wa, ram_ra;
	logic [63:0] ram_wd, ram_rd;

	logic        is_upd, is_page, is_begin, is_commit;
	logic        over, big, tfull, zlen, early;
	logic [15:0] data_nx;
	logic [CW-1:0] scan_p1;
	logic [23:0] pos_nx;
	logic [24:0] fill_sum;

	assign is_upd    = (kind_q == wrs_pkg::KIND_UPDATE);
	assign is_page   = (kind_q == wrs_pkg::KIND_ALLOC) || (kind_q == wrs_pkg::KIND_FREE);
	assign is_begin  = (kind_q == wrs_pkg::KIND_BEGIN);
	assign is_commit = (kind_q == wrs_pkg::KIND_COMMIT);

	always_comb begin
		if (is_upd) data_nx = 16'({8'd0, upd_fix_q} + {len_q, 1'b0});
		else if (is_page) data_nx = {8'd0, page_pl_q};
		else data_nx = 16'd0;
	end

	assign fill_sum = {1'b0, fill_q} + {8'd0, total_q};
	assign over  = fill_sum > {1'b0, buf_q};
	assign big   = {8'd0, total_q} > {1'b0, buf_q};
	assign tfull = is_begin && (count_q >= MAX_CNT);
	assign zlen  = is_upd && (len_q == 16'd0);
	assign early = tfull || zlen;
	assign pos_nx = over ? 24'd0 : fill_q;
	assign scan_p1 = scan_q + 1'b1;

	// Table port: read at the scan position, or one above it while shifting
	assign ram_ra = cmd.rd_plus1 ? scan_p1[IW-1:0] : scan_q[IW-1:0];
	always_comb begin
		ram_we = 1'b0;
		ram_wa = hit_q;
		ram_wd = {seq_q, tx_q};
		if (cmd.upd && found_q) begin
			ram_we = 1'b1;
		end else if (cmd.ins) begin
			ram_we = 1'b1;
			ram_wa = count_q[IW-1:0];
			ram_wd = {(found_q ? 32'd0 : seq_q), tx_q};
		end else if (cmd.shift_wr) begin
			ram_we = 1'b1;
			ram_wa = scan_q[IW-1:0];
			ram_wd = ram_rd;
		end
	end

	wrs_ram #(.WIDTH(64), .DEPTH(MAX_ACTIVE)) u_table (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_wa),
		.wr_data (ram_wd),
		.rd_addr (ram_ra),
		.rd_data (ram_rd)
	);

	// Control state: configuration, counters, fill level, table size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q       <= 24'd65536;
			hdr_q       <= 8'd32;
			upd_fix_q   <= 8'd8;
			page_pl_q   <= 8'd4;
			next_seq_q  <= 32'd1;
			next_txn_q  <= 32'd1;
			fill_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					wrs_pkg::REG_BUFFER:     buf_q      <= cfg_data[23:0];
					wrs_pkg::REG_HEADER:     hdr_q      <= cfg_data[7:0];
					wrs_pkg::REG_UPD_FIXED:  upd_fix_q  <= cfg_data[7:0];
					wrs_pkg::REG_PAGE_PL:    page_pl_q  <= cfg_data[7:0];
					wrs_pkg::REG_FIRST_LSN:  next_seq_q <= cfg_data;
					wrs_pkg::REG_FIRST_TXID: next_txn_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.check && !early) begin
				if (over) fill_q <= 24'd0;
				if (is_begin) next_txn_q <= next_txn_q + 32'd1;
				if (!big) begin
					next_seq_q <= next_seq_q + 32'd1;
					fill_q <= is_commit ? 24'd0 : 24'(pos_nx + {7'd0, total_q});
				end
			end
			if (cmd.ins) count_q <= count_q + 1'b1;
			if (cmd.shift_done) count_q <= count_q - 1'b1;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Item and work registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_kind;
			txn_q  <= in_data[31:0];
			page_q <= in_data[63:32];
			off_q  <= in_data[79:64];
			len_q  <= in_data[95:80];
		end
		if (cmd.size) begin
			data_q  <= data_nx;
			total_q <= {9'd0, hdr_q} + {1'b0, data_nx};
		end
		if (cmd.check) begin
			fail_q  <= early || big;
			fb_q    <= !early && over;
			tx_q    <= is_begin ? next_txn_q : txn_q;
			seq_q   <= next_seq_q;
			pos_q   <= pos_nx;
			prev_q  <= '0;
			found_q <= 1'b0;
			scan_q  <= '0;
			if (tfull) status_q <= wrs_pkg::STAT_TFULL;
			else if (zlen) status_q <= wrs_pkg::STAT_ZERO;
			else if (big) status_q <= wrs_pkg::STAT_FULL;
			else status_q <= wrs_pkg::STAT_OK;
		end
		if (cmd.cmp_step) begin
			if (ram_rd[31:0] == tx_q) begin
				found_q <= 1'b1;
				hit_q   <= scan_q[IW-1:0];
				prev_q  <= ram_rd[63:32];
			end else begin
				scan_q <= scan_p1;
			end
		end
		if (cmd.upd) scan_q <= {{(CW-IW){1'b0}}, hit_q};
		if (cmd.shift_wr) scan_q <= scan_p1;
		if (cmd.emit) begin
			out_user_q <= {kind_q, status_q};
			out_data_q <= {6'd0,
				is_upd ? len_q : 16'd0,
				is_upd ? off_q : 16'd0,
				(is_upd || is_page) ? page_q : 32'd0,
				!fail_q && is_commit,
				fb_q,
				fail_q ? 24'd0 : pos_q,
				fail_q ? 16'd0 : data_q,
				fail_q ? 32'd0 : prev_q,
				fail_q ? 32'd0 : seq_q,
				fail_q ? 32'd0 : tx_q};
		end
	end

	always_comb begin
		sts            = '0;
		sts.kind_ok    = (in_kind <= wrs_pkg::KIND_ABORT);
		sts.fail       = early || big;
		sts.more       = scan_q < count_q;
		sts.hit        = ram_rd[31:0] == tx_q;
		sts.more_shift = scan_p1 < count_q;
		sts.found      = found_q;
		sts.is_begin   = is_begin;
		sts.is_remove  = is_commit || (kind_q == wrs_pkg::KIND_ABORT);
		sts.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_user  = out_user_q;
	assign out_data  = out_data_q;

endmodule

### src/wal_record_sequencer.sv
`timescale 1ns / 1ps
// Steps from accept to result: size and check, then straight to the result on an error; otherwise a
//   table scan up to a match or the end of the table, the update, an insert for a begin, and for a
//   commit or abort that removes an entry a shift down of every entry behind it, then the result.
// Throughput: one item at a time; the next item is taken the cycle after the result is loaded,
//   so a result held by m_tready stalls the input. The table scan sets the rate.
// Reset (arst_n low): configuration and counters to defaults, fill level and table size cleared.
// ----------------------------------------------------------------------------
// wal_record_sequencer
// Write-ahead log record sizing, LSN assignment and per-transaction chaining.
// ----------------------------------------------------------------------------
`include "wal_record_sequencer_assert.svh"

module wal_record_sequencer #(
	parameter int MAX_ACTIVE = wrs_pkg::MAX_ACTIVE_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// configuration writes
	input  logic         cfg_wen,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	// request items
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [2:0]   s_tuser,  // kind
	input  logic [95:0]  s_tdata,  // txn, page_number, byte_offset, image_bytes
	// result items
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [4:0]   m_tuser,  // status, record_type
	output logic [207:0] m_tdata   // txn_out, seq, prev_seq, payload_bytes, write_position,
	                               // flush_before, flush_after, page_out, offset_out,
	                               // length_out, zero pad
);

	wrs_pkg::cmd_t cmd;
	wrs_pkg::sts_t sts;

	// Controller sequences the steps; datapath holds the configuration, counters, work registers and the table
	wrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wrs_dp #(.MAX_ACTIVE(MAX_ACTIVE)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_kind   (s_tuser),
		.in_data   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_user  (m_tuser),
		.out_data  (m_tdata)
	);

	// An accepted item of a known kind keeps the input closed in the next cycle
	`WRS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready && s_tuser <= wrs_pkg::KIND_ABORT, !s_tready, "input open after accept")
	// A result load always shows up on the output
	`WRS_ASSERT_NEXT(a_emit_visible, cmd.emit, m_tvalid, "emitted result not valid")
	// At most one step command at a time
	`WRS_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0(cmd & ~10'b0001000000), "conflicting datapath commands")

endmodule

### verif/wal_record_sequencer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wal_record_sequencer_test
// Self-checking bench for the log record sequencer. A queue-fed driver offers
// log requests, a shadow of the transaction table and counters predicts each
// record, and a monitor compares every result item field by field.
// ----------------------------------------------------------------------------
module wal_record_sequencer_test;

	localparam int TABLE_DEPTH = wrs_pkg::MAX_ACTIVE_DEF;
	localparam int SETTLE_CYCLES = 300;	// worst scan plus shift of a full table

	typedef struct {
		logic [2:0]  kind;
		logic [31:0] txn;
		logic [31:0] page;
		logic [15:0] offs;
		logic [15:0] len;
	} request_t;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] txn_out;
		logic [31:0] seq;
		logic [31:0] prev_seq;
		logic [2:0]  record_type;
		logic [15:0] payload_bytes;
		logic [23:0] write_position;
		logic        flush_before;
		logic        flush_after;
		logic [31:0] page_out;
		logic [15:0] offset_out;
		logic [15:0] length_out;
	} record_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_wen;
	logic [2:0]   cfg_index;
	logic [31:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [2:0]   s_tuser;	// kind
	logic [95:0]  s_tdata;	// txn, page_number, byte_offset, image_bytes
	logic         m_tvalid;
	logic         m_tready;
	logic [4:0]   m_tuser;	// status, record_type
	logic [207:0] m_tdata;	// txn_out, seq, prev_seq, payload_bytes, write_position,
				// flush_before, flush_after, page_out, offset_out, length_out

	wal_record_sequencer uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata)
	);

	// Shadow of the block: configuration, transaction table and counters
	logic [23:0] buf_cap;
	logic [7:0]  hdr_size;
	logic [7:0]  upd_fixed;
	logic [7:0]  page_pl;
	logic [31:0] sh_ids [TABLE_DEPTH];
	logic [31:0] sh_last [TABLE_DEPTH];
	int          sh_count;
	logic [31:0] sh_next_seq;
	logic [31:0] sh_next_txn;
	logic [23:0] sh_fill;

	request_t pending_reqs [$];
	record_t  expected_records [$];
	int       err_count;
	logic     req_taken;
	int       tx_idle_pct;
	int       rx_idle_pct;
	int       stall_trigger;
	logic [31:0] gen_id_base;
	int          gen_begins;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Apply a register write to the shadow
	function automatic void shadow_config(logic [2:0] idx, logic [31:0] val);
		case (idx)
			wrs_pkg::REG_BUFFER: buf_cap = val[23:0];
			wrs_pkg::REG_HEADER: hdr_size = val[7:0];
			wrs_pkg::REG_UPD_FIXED: upd_fixed = val[7:0];
			wrs_pkg::REG_PAGE_PL: page_pl = val[7:0];
			wrs_pkg::REG_FIRST_LSN: sh_next_seq = val;
			wrs_pkg::REG_FIRST_TXID: sh_next_txn = val;
			default: ;
		endcase
	endfunction

	// Size, sequence and chain one request; queue the record it produces
	function automatic void sequence_request(request_t rq);
		record_t r;
		logic [15:0] data;
		longint unsigned total;
		logic [31:0] id;
		int idx;
		if (rq.kind > wrs_pkg::KIND_ABORT)
			return;	// unknown kinds are dropped without a result
		r = '{default: '0};
		r.record_type = rq.kind;
		if (rq.kind == wrs_pkg::KIND_UPDATE || rq.kind == wrs_pkg::KIND_ALLOC ||
			rq.kind == wrs_pkg::KIND_FREE)
			r.page_out = rq.page;
		if (rq.kind == wrs_pkg::KIND_UPDATE) begin
			r.offset_out = rq.offs;
			r.length_out = rq.len;
		end
		if (rq.kind == wrs_pkg::KIND_BEGIN && sh_count >= TABLE_DEPTH) begin
			r.status = wrs_pkg::STAT_TFULL;
			expected_records.push_back(r);
			return;
		end
		if (rq.kind == wrs_pkg::KIND_UPDATE && rq.len == 16'd0) begin
			r.status = wrs_pkg::STAT_ZERO;
			expected_records.push_back(r);
			return;
		end
		data = 16'd0;
		if (rq.kind == wrs_pkg::KIND_UPDATE)
			data = 16'(upd_fixed + 2 * rq.len);
		else if (rq.kind == wrs_pkg::KIND_ALLOC || rq.kind == wrs_pkg::KIND_FREE)
			data = 16'(page_pl);
		total = longint'(hdr_size) + longint'(data);
		id = rq.txn;
		if (rq.kind == wrs_pkg::KIND_BEGIN) begin
			id = sh_next_txn;
			sh_next_txn = sh_next_txn + 1;
			sh_ids[sh_count] = id;
			sh_last[sh_count] = 32'd0;
			sh_count++;
		end
		// flush first when the record does not fit behind the current fill
		if (longint'(sh_fill) + total > longint'(buf_cap)) begin
			sh_fill = 24'd0;
			r.flush_before = 1'b1;
		end
		if (total > longint'(buf_cap)) begin
			if (rq.kind == wrs_pkg::KIND_BEGIN)
				sh_count--;	// roll back the entry, the id stays used
			r.status = wrs_pkg::STAT_FULL;
			expected_records.push_back(r);
			return;
		end
		r.seq = sh_next_seq;
		sh_next_seq = sh_next_seq + 1;
		idx = -1;
		for (int i = 0; i < sh_count; i++)
			if (idx < 0 && sh_ids[i] == id)
				idx = i;
		if (idx >= 0) begin
			r.prev_seq = sh_last[idx];
			sh_last[idx] = r.seq;
		end
		r.write_position = sh_fill;
		sh_fill = 24'(longint'(sh_fill) + total);
		if ((rq.kind == wrs_pkg::KIND_COMMIT || rq.kind == wrs_pkg::KIND_ABORT) && idx >= 0) begin
			for (int i = idx; i + 1 < sh_count; i++) begin
				sh_ids[i] = sh_ids[i + 1];
				sh_last[i] = sh_last[i + 1];
			end
			sh_count--;
		end
		if (rq.kind == wrs_pkg::KIND_COMMIT) begin
			sh_fill = 24'd0;
			r.flush_after = 1'b1;
		end
		r.status = wrs_pkg::STAT_OK;
		r.txn_out = id;
		r.payload_bytes = data;
		expected_records.push_back(r);
	endfunction

	// Driver: hold an offered item until taken, then advance the queue
	always @(negedge clk) begin : req_driver
		logic offer;
		if (req_taken)
			void'(pending_reqs.pop_front());
		offer = s_tvalid && !req_taken;
		if (!offer && pending_reqs.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct)
			offer = 1'b1;
		if (offer) begin
			s_tuser <= pending_reqs[0].kind;
			s_tdata <= {pending_reqs[0].len, pending_reqs[0].offs,
				pending_reqs[0].page, pending_reqs[0].txn};
		end
		s_tvalid <= offer;
	end

	// Receiver: random stalls plus a long hold-off on request
	always @(negedge clk) begin : rsp_driver
		int seen;
		int hold;
		if (stall_trigger != seen) begin
			seen = stall_trigger;
			hold = 600;
		end else if (hold > 0) begin
			hold--;
		end
		m_tready <= (hold == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// Monitor: predict on every accepted request, check every accepted result
	always @(posedge clk) begin : monitor
		request_t rq;
		record_t got;
		record_t exp_r;
		req_taken <= s_tvalid && s_tready;
		if (cfg_wen)
			shadow_config(cfg_index, cfg_data);
		if (s_tvalid && s_tready) begin
			rq.kind = s_tuser;
			{rq.len, rq.offs, rq.page, rq.txn} = s_tdata;
			sequence_request(rq);
		end
		if (m_tvalid && m_tready) begin
			got.status = m_tuser[1:0];
			got.record_type = m_tuser[4:2];
			got.txn_out = m_tdata[31:0];
			got.seq = m_tdata[63:32];
			got.prev_seq = m_tdata[95:64];
			got.payload_bytes = m_tdata[111:96];
			got.write_position = m_tdata[135:112];
			got.flush_before = m_tdata[136];
			got.flush_after = m_tdata[137];
			got.page_out = m_tdata[169:138];
			got.offset_out = m_tdata[185:170];
			got.length_out = m_tdata[201:186];
			if (expected_records.size() == 0) begin
				$error("result item with no record expected");
				err_count++;
			end else begin
				exp_r = expected_records.pop_front();
				if (got.status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, got.status);
					err_count++;
				end
				if (got.record_type !== exp_r.record_type) begin
					$error("record_type: expected %0d, got %0d", exp_r.record_type,
						got.record_type);
					err_count++;
				end
				if (got.txn_out !== exp_r.txn_out) begin
					$error("txn_out: expected %h, got %h", exp_r.txn_out, got.txn_out);
					err_count++;
				end
				if (got.seq !== exp_r.seq) begin
					$error("seq: expected %h, got %h", exp_r.seq, got.seq);
					err_count++;
				end
				if (got.prev_seq !== exp_r.prev_seq) begin
					$error("prev_seq: expected %h, got %h", exp_r.prev_seq, got.prev_seq);
					err_count++;
				end
				if (got.payload_bytes !== exp_r.payload_bytes) begin
					$error("payload_bytes: expected %0d, got %0d", exp_r.payload_bytes,
						got.payload_bytes);
					err_count++;
				end
				if (got.write_position !== exp_r.write_position) begin
					$error("write_position: expected %0d, got %0d", exp_r.write_position,
						got.write_position);
					err_count++;
				end
				if (got.flush_before !== exp_r.flush_before) begin
					$error("flush_before: expected %b, got %b", exp_r.flush_before,
						got.flush_before);
					err_count++;
				end
				if (got.flush_after !== exp_r.flush_after) begin
					$error("flush_after: expected %b, got %b", exp_r.flush_after,
						got.flush_after);
					err_count++;
				end
				if (got.page_out !== exp_r.page_out) begin
					$error("page_out: expected %h, got %h", exp_r.page_out, got.page_out);
					err_count++;
				end
				if (got.offset_out !== exp_r.offset_out) begin
					$error("offset_out: expected %h, got %h", exp_r.offset_out,
						got.offset_out);
					err_count++;
				end
				if (got.length_out !== exp_r.length_out) begin
					$error("length_out: expected %h, got %h", exp_r.length_out,
						got.length_out);
					err_count++;
				end
			end
		end
	end

	task automatic push_req(logic [2:0] kind, logic [31:0] txn, logic [31:0] page,
		logic [15:0] offs, logic [15:0] len);
		request_t rq;
		rq = '{kind: kind, txn: txn, page: page, offs: offs, len: len};
		if (kind == wrs_pkg::KIND_BEGIN)
			gen_begins++;
		pending_reqs.push_back(rq);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wen <= 1'b0;
		if (idx == wrs_pkg::REG_FIRST_TXID) begin
			gen_id_base = val;
			gen_begins = 0;
		end
	endtask

	// Wait until every request is taken and every record has come back
	task automatic drain();
		while (pending_reqs.size() > 0 || s_tvalid || expected_records.size() > 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Mostly ids near the recent begins, so records chain; some strangers
	task automatic push_random(int count);
		int roll;
		logic [2:0] kind;
		logic [31:0] txn;
		logic [15:0] len;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 20) kind = wrs_pkg::KIND_BEGIN;
			else if (roll < 55) kind = wrs_pkg::KIND_UPDATE;
			else if (roll < 65) kind = wrs_pkg::KIND_ALLOC;
			else if (roll < 75) kind = wrs_pkg::KIND_FREE;
			else if (roll < 85) kind = wrs_pkg::KIND_COMMIT;
			else if (roll < 95) kind = wrs_pkg::KIND_ABORT;
			else kind = 3'($urandom_range(6, 7));
			if ($urandom_range(0, 99) < 85)
				txn = gen_id_base + 32'($urandom_range(0, gen_begins + 1));
			else
				txn = $urandom;
			len = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 40)) : 16'($urandom);
			push_req(kind, txn, $urandom, 16'($urandom), len);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tuser = '0;
		s_tdata = '0;
		m_tready = 1'b0;
		req_taken = 1'b0;
		err_count = 0;
		stall_trigger = 0;
		tx_idle_pct = 30;
		rx_idle_pct = 84;
		gen_id_base = 32'd1;
		gen_begins = 0;
		buf_cap = 24'd65536;
		hdr_size = 8'd32;
		upd_fixed = 8'd8;
		page_pl = 8'd4;
		sh_count = 0;
		sh_next_seq = 32'd1;
		sh_next_txn = 32'd1;
		sh_fill = 24'd0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Directed: every kind, field extremes, zero-length update, unknown kinds,
		// unknown transaction, removal from the middle of the table
		push_req(wrs_pkg::KIND_BEGIN, 32'hFFFF_FFFF, 32'd0, 16'd0, 16'd0);
		push_req(wrs_pkg::KIND_BEGIN, 32'd0, 32'd0, 16'd0, 16'd0);
		push_req(wrs_pkg::KIND_BEGIN, 32'd0, 32'd0, 16'd0, 16'd0);
		push_req(wrs_pkg::KIND_UPDATE, 32'd1, 32'hFFFF_FFFF, 16'hFFFF, 16'd1);
		push_req(wrs_pkg::KIND_UPDATE, 32'd2, 32'd0, 16'd0, 16'hFFFF);
		push_req(wrs_pkg::KIND_UPDATE, 32'd3, 32'h5A5A_A5A5, 16'h1234, 16'd0);
		push_req(wrs_pkg::KIND_UPDATE, 32'd2, 32'd7, 16'd9, 16'h7FFC);
		push_req(wrs_pkg::KIND_ALLOC, 32'd3, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		push_req(wrs_pkg::KIND_FREE, 32'd1, 32'd0, 16'd0, 16'd0);
		push_req(3'd6, 32'd1, 32'd1, 16'd1, 16'd1);
		push_req(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		push_req(wrs_pkg::KIND_UPDATE, 32'd0, 32'd1, 16'd2, 16'd3);
		push_req(wrs_pkg::KIND_COMMIT, 32'd2, 32'd0, 16'd0, 16'd0);
		push_req(wrs_pkg::KIND_UPDATE, 32'd3, 32'd4, 16'd5, 16'd6);
		push_req(wrs_pkg::KIND_ABORT, 32'd1, 32'd0, 16'd0, 16'd0);
		push_req(wrs_pkg::KIND_COMMIT, 32'hDEAD_BEEF, 32'd0, 16'd0, 16'd0);
		push_req(wrs_pkg::KIND_UPDATE, 32'd2, 32'd8, 16'd8, 16'd8);
		push_req(wrs_pkg::KIND_COMMIT, 32'd3, 32'd0, 16'd0, 16'd0);
		drain();

		// Tight buffer: frequent flushes before the record and full failures
		write_reg(wrs_pkg::REG_BUFFER, 32'd300);
		write_reg(wrs_pkg::REG_HEADER, 32'd40);
		write_reg(wrs_pkg::REG_UPD_FIXED, 32'd255);
		write_reg(wrs_pkg::REG_PAGE_PL, 32'd255);
		push_random(300);
		drain();

		// Smallest sizes, counters right at the wrap; restarted ids may collide
		write_reg(wrs_pkg::REG_BUFFER, 32'd1);
		write_reg(wrs_pkg::REG_HEADER, 32'd1);
		write_reg(wrs_pkg::REG_UPD_FIXED, 32'd0);
		write_reg(wrs_pkg::REG_PAGE_PL, 32'd0);
		write_reg(wrs_pkg::REG_FIRST_LSN, 32'hFFFF_FFFF);
		write_reg(wrs_pkg::REG_FIRST_TXID, 32'hFFFF_FFFE);
		push_random(150);
		drain();

		// Largest sizes, swapped idling
		tx_idle_pct = 84;
		rx_idle_pct = 30;
		write_reg(wrs_pkg::REG_BUFFER, 32'hFF_FFFF);
		write_reg(wrs_pkg::REG_HEADER, 32'd255);
		write_reg(wrs_pkg::REG_UPD_FIXED, 32'd255);
		write_reg(wrs_pkg::REG_PAGE_PL, 32'd255);
		write_reg(wrs_pkg::REG_FIRST_LSN, 32'd1000);
		write_reg(wrs_pkg::REG_FIRST_TXID, 32'd5);
		push_random(400);
		drain();

		// Fill the table past its size while the receiver holds off
		write_reg(wrs_pkg::REG_HEADER, 32'd32);
		write_reg(wrs_pkg::REG_UPD_FIXED, 32'd8);
		write_reg(wrs_pkg::REG_PAGE_PL, 32'd4);
		write_reg(wrs_pkg::REG_FIRST_TXID, 32'h8000_0000);
		stall_trigger++;
		for (int i = 0; i < TABLE_DEPTH + 6; i++)
			push_req(wrs_pkg::KIND_BEGIN, 32'd0, 32'd0, 16'd0, 16'd0);
		for (int i = 0; i < TABLE_DEPTH + 2; i++)
			push_req(($urandom_range(0, 1) != 0) ? wrs_pkg::KIND_COMMIT : wrs_pkg::KIND_ABORT,
				32'h8000_0000 + 32'($urandom_range(0, TABLE_DEPTH - 1)), 32'd0, 16'd0, 16'd0);
		drain();

		// Back to default sizes: swapped idling, then none
		tx_idle_pct = 84;
		rx_idle_pct = 30;
		write_reg(wrs_pkg::REG_BUFFER, 32'd65536);
		write_reg(wrs_pkg::REG_FIRST_LSN, 32'd1);
		push_random(300);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		push_random(650);
		drain();

		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
